### sv/fhdf_pkg.sv
// Shared types, constants and the FNV-1a byte fold for the frame hash duplicate filter.
package fhdf_pkg;

    // FNV-1a 32-bit constants.
    localparam logic [31:0] FNV_BASIS = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME = 32'd16777619;

    // Default number of hashes held in the history.
    localparam int HISTORY_DEPTH_DEF = 512;

    // Transaction kinds on the kind port.
    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    // Controller states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_APPEND
    } state_t;

    // Control from the controller to the hash unit.
    typedef struct packed {
        logic fold;
        logic restart;
    } hash_ctl_t;

    // Fold one byte into a running hash: xor, then multiply modulo 2^32.
    function automatic logic [31:0] fnv_fold(input logic [31:0] h, input logic [7:0] b);
        logic [31:0] x;
        x = h ^ {24'd0, b};
        return x * FNV_PRIME;
    endfunction

endpackage

### sv/fhdf_hasher.sv
// Running FNV-1a hash register with its one-byte fold unit.
module fhdf_hasher (
    input  logic                clk,
    input  logic                rst_n,
    input  fhdf_pkg::hash_ctl_t ctl,
    input  logic [7:0]          key_byte,
    output logic [31:0]         fold_hash
);
    import fhdf_pkg::*;

    logic [31:0] running_reg;
    logic [31:0] running_next;

    // The fold of the current byte into the hash so far.
    assign fold_hash = fnv_fold(running_reg, key_byte);

    // A finished or discarded key restarts from the offset basis.
    always_comb
    begin
        running_next = running_reg;
        if (ctl.restart)
        begin
            running_next = FNV_BASIS;
        end
        else if (ctl.fold)
        begin
            running_next = fold_hash;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg <= FNV_BASIS;
        end
        else
        begin
            running_reg <= running_next;
        end
    end

endmodule

### sv/fhdf_history.sv
// Hash history memory: one write port and one registered read port.
module fhdf_history #(
    parameter int HISTORY_DEPTH = fhdf_pkg::HISTORY_DEPTH_DEF,
    parameter int PTR_W         = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [PTR_W-1:0] wr_addr,
    input  logic [31:0]      wr_data,
    input  logic             rd_en,
    input  logic [PTR_W-1:0] rd_addr,
    output logic [31:0]      rd_data
);
    import fhdf_pkg::*;

    logic [31:0] mem [HISTORY_DEPTH];
    logic [31:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### sv/frame_hash_duplicate_filter.sv
// Top level of the frame hash duplicate filter: controller, hash unit and history.
//
// Key bytes are taken one per clock cycle while busy is low, and folded into a
// 32-bit FNV-1a hash; busy stays low while a key is being hashed. The byte marked
// last starts a lookup that reads the history memory one entry per cycle through
// its single read port. A new key is compared with every entry, then appends its
// hash. A repeated key stops at its matching entry. A key that meets an empty
// history only appends its hash. The result strobe done comes in the cycle that
// busy falls. An empty key gives its result in the cycle after it is taken; a clear
// transaction gives no result and leaves busy low. The strobe done is high for a
// single cycle with each result on duplicate and key_hash, which hold it until the
// next result, and the receiver cannot stall it.
module frame_hash_duplicate_filter #(
    parameter int HISTORY_DEPTH = fhdf_pkg::HISTORY_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [7:0]  key_byte,
    input  logic        last_byte,
    output logic        done,
    output logic        duplicate,
    output logic [31:0] key_hash
);
    import fhdf_pkg::*;

    localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(HISTORY_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);

    state_t           state_reg, state_next;
    logic [31:0]      hash_reg, hash_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [CNT_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0] issue_reg, issue_next;
    logic             rdv_reg, rdv_next;
    logic             rdlast_reg, rdlast_next;
    logic             done_reg, done_next;
    logic             dup_reg, dup_next;
    logic [31:0]      out_hash_reg, out_hash_next;

    logic             accept;
    logic             issue_ok;
    logic             match;
    logic             wr_en;
    logic [31:0]      fold_hash;
    logic [31:0]      rd_data;
    hash_ctl_t        hash_ctl;

    assign busy     = (state_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign issue_ok = (issue_reg < fill_reg);
    assign match    = rdv_reg && (rd_data == hash_reg);
    assign wr_en    = (state_reg == ST_APPEND);

    // Hash unit control: every key byte folds, a finished or empty key restarts.
    always_comb
    begin
        hash_ctl.fold    = accept && (kind == KIND_BYTE);
        hash_ctl.restart = accept && ((kind == KIND_EMPTY) ||
                                      ((kind == KIND_BYTE) && last_byte));
    end

    fhdf_hasher u_hasher (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (hash_ctl),
        .key_byte  (key_byte),
        .fold_hash (fold_hash)
    );

    fhdf_history #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .PTR_W         (PTR_W)
    ) u_history (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wp_reg),
        .wr_data (hash_reg),
        .rd_en   ((state_reg == ST_SCAN) && issue_ok),
        .rd_addr (issue_reg[PTR_W-1:0]),
        .rd_data (rd_data)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (kind == KIND_BYTE) && last_byte)
                begin
                    state_next = (fill_reg == '0) ? ST_APPEND : ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (match)
                begin
                    state_next = ST_IDLE;
                end
                else if (rdv_reg && rdlast_reg)
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath and result registers.
    always_comb
    begin
        hash_next     = hash_reg;
        wp_next       = wp_reg;
        fill_next     = fill_reg;
        issue_next    = issue_reg;
        rdv_next      = 1'b0;
        rdlast_next   = 1'b0;
        done_next     = 1'b0;
        dup_next      = dup_reg;
        out_hash_next = out_hash_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if ((kind == KIND_BYTE) && last_byte)
                    begin
                        hash_next  = fold_hash;
                        issue_next = '0;
                    end
                    else if (kind == KIND_EMPTY)
                    begin
                        done_next     = 1'b1;
                        dup_next      = 1'b0;
                        out_hash_next = '0;
                    end
                    else if (kind == KIND_CLEAR)
                    begin
                        wp_next   = '0;
                        fill_next = '0;
                    end
                end
            end
            ST_SCAN:
            begin
                // One read issued per cycle, compared in the next cycle.
                if (issue_ok)
                begin
                    rdv_next    = 1'b1;
                    rdlast_next = (issue_reg == (fill_reg - CNT_W'(1)));
                    issue_next  = issue_reg + CNT_W'(1);
                end
                if (match)
                begin
                    rdv_next      = 1'b0;
                    done_next     = 1'b1;
                    dup_next      = 1'b1;
                    out_hash_next = hash_reg;
                end
            end
            ST_APPEND:
            begin
                // New key: its hash goes to the oldest slot once the history is full.
                wp_next       = (wp_reg == PTR_LAST) ? '0 : wp_reg + PTR_W'(1);
                fill_next     = (fill_reg == FILL_MAX) ? fill_reg : fill_reg + CNT_W'(1);
                done_next     = 1'b1;
                dup_next      = 1'b0;
                out_hash_next = hash_reg;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            wp_reg     <= '0;
            fill_reg   <= '0;
            issue_reg  <= '0;
            rdv_reg    <= 1'b0;
            rdlast_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            wp_reg     <= wp_next;
            fill_reg   <= fill_next;
            issue_reg  <= issue_next;
            rdv_reg    <= rdv_next;
            rdlast_reg <= rdlast_next;
            done_reg   <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        hash_reg     <= hash_next;
        dup_reg      <= dup_next;
        out_hash_reg <= out_hash_next;
    end

    assign done      = done_reg;
    assign duplicate = dup_reg;
    assign key_hash  = out_hash_reg;

endmodule

### sv/fhdf_checker.sv
// Port-level checker for the frame hash duplicate filter, bound to the top level.
module fhdf_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic [1:0]  kind,
    input logic        last_byte,
    input logic        done,
    input logic        duplicate,
    input logic [31:0] key_hash
);
    import fhdf_pkg::*;

    // An empty key gives a not-duplicate result with a zero hash in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == KIND_EMPTY)) |=> (done && !duplicate && (key_hash == '0)))
    else $error("empty key transaction did not give a zero result");

    // A last key byte starts a lookup.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == KIND_BYTE) && last_byte) |=> (busy && !done))
    else $error("last key byte did not start a lookup");

    // A middle key byte or a clear gives no result and leaves the block free.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (((kind == KIND_BYTE) && !last_byte) || (kind == KIND_CLEAR)))
        |=> (!done && !busy))
    else $error("transaction without a result produced one or blocked input");

    // A lookup only ends together with its result.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
    else $error("lookup ended without a result");

    // A result never appears without a transaction or lookup behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(busy) || $past(start && (kind == KIND_EMPTY))))
    else $error("result strobe without a cause");

endmodule

bind frame_hash_duplicate_filter fhdf_checker u_fhdf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .kind      (kind),
    .last_byte (last_byte),
    .done      (done),
    .duplicate (duplicate),
    .key_hash  (key_hash)
);
